/* rtl/srfp_pkg.sv */
// Shared types and constants for the serial reply frame parser.
package srfp_pkg;

    localparam int RESPONSE_BYTES_DEF = 32;

    localparam logic [7:0] START_MARK = 8'h3B;
    localparam logic [7:0] MIN_LENGTH = 8'd3;
    localparam int         HEADER_BYTES = 3;

    localparam logic [7:0] RST_EXPECTED_SOURCE  = 8'd18;
    localparam logic [7:0] RST_OWN_ADDRESS      = 8'd32;
    localparam logic [7:0] RST_EXPECTED_COMMAND = 8'd1;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_BAD_START  = 3'd1,
        ST_BAD_LENGTH = 3'd2,
        ST_BAD_SUM    = 3'd3,
        ST_MISMATCH   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CFG_EXPECTED_SOURCE  = 2'd0,
        CFG_OWN_ADDRESS      = 2'd1,
        CFG_EXPECTED_COMMAND = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [7:0] expected_source;
        logic [7:0] own_address;
        logic [7:0] expected_command;
    } t_cfg;

    typedef struct packed {
        logic       is_status;
        logic [7:0] payload_byte;
        logic [4:0] byte_index;
        t_status    status_code;
        logic [4:0] payload_length;
        logic       last;
    } t_item;

endpackage

/* rtl/srfp_buf.sv */
// Payload buffer: one write port, one read port with registered read data.
module srfp_buf #(
    parameter int DEPTH = srfp_pkg::RESPONSE_BYTES_DEF - 6,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/srfp_parse.sv */
// Frame parser and payload release sequencer around the payload buffer.
module srfp_parse #(
    parameter int RESPONSE_BYTES = srfp_pkg::RESPONSE_BYTES_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic [7:0]           i_rx_byte,
    output logic                 o_stall,
    input  srfp_pkg::t_cfg       i_cfg,
    output srfp_pkg::t_item      o_item,
    output logic                 o_item_valid,
    input  logic                 i_item_ready
);

    localparam int MAX_LENGTH  = RESPONSE_BYTES - 3;
    localparam int STORE_DEPTH = RESPONSE_BYTES - 6;
    localparam int LEN_W       = $clog2(MAX_LENGTH + 1);
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int PL_W        = $clog2(STORE_DEPTH + 1);
    localparam logic [7:0] MAX_LENGTH_B = 8'(MAX_LENGTH);

    typedef enum logic [4:0] {
        PH_HUNT   = 5'b00001,
        PH_LENGTH = 5'b00010,
        PH_BODY   = 5'b00100,
        PH_READ   = 5'b01000,
        PH_PUSH   = 5'b10000
    } t_phase;

    t_phase          r_phase, n_phase;
    logic [LEN_W-1:0] r_flen, n_flen;
    logic [LEN_W-1:0] r_pos, n_pos;
    logic [7:0]      r_sum, n_sum;
    logic            r_mis, n_mis;
    logic [PL_W-1:0] r_plen, n_plen;
    logic [PL_W-1:0] r_rd_idx, n_rd_idx;
    logic            r_pend_valid, n_pend_valid;
    srfp_pkg::t_item r_pend, n_pend;

    logic             accept;
    logic             take_input;
    logic             buf_we;
    logic [IDX_W-1:0] buf_waddr;
    logic             buf_re;
    logic [7:0]       buf_rdata;
    logic [7:0]       sum_next;
    logic             mis_next;

    srfp_buf #(
        .DEPTH (STORE_DEPTH),
        .AW    (IDX_W)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (buf_we),
        .i_waddr (buf_waddr),
        .i_wdata (i_rx_byte),
        .i_re    (buf_re),
        .i_raddr (r_rd_idx[IDX_W-1:0]),
        .o_rdata (buf_rdata)
    );

    assign take_input = !r_pend_valid
                        && (r_phase == PH_HUNT || r_phase == PH_LENGTH || r_phase == PH_BODY);
    assign o_stall    = !take_input;
    assign accept     = i_valid && take_input;

    assign sum_next  = r_sum + i_rx_byte;
    assign buf_waddr = IDX_W'(r_pos - LEN_W'(srfp_pkg::HEADER_BYTES));

    always_comb begin
        mis_next = r_mis;
        if (r_pos == LEN_W'(0)) begin
            mis_next = r_mis || (i_rx_byte != i_cfg.expected_source);
        end else if (r_pos == LEN_W'(1)) begin
            mis_next = r_mis || (i_rx_byte != i_cfg.own_address);
        end else if (r_pos == LEN_W'(2)) begin
            mis_next = r_mis || (i_rx_byte != i_cfg.expected_command);
        end
    end

    always_comb begin
        o_item_valid = r_pend_valid || (r_phase == PH_PUSH);
        if (r_phase == PH_PUSH) begin
            o_item.is_status      = 1'b0;
            o_item.payload_byte   = buf_rdata;
            o_item.byte_index     = 5'(r_rd_idx);
            o_item.status_code    = srfp_pkg::ST_OK;
            o_item.payload_length = 5'(r_plen);
            o_item.last           = 1'b0;
        end else begin
            o_item = r_pend;
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_flen       = r_flen;
        n_pos        = r_pos;
        n_sum        = r_sum;
        n_mis        = r_mis;
        n_plen       = r_plen;
        n_rd_idx     = r_rd_idx;
        n_pend_valid = r_pend_valid;
        n_pend       = r_pend;
        buf_we       = 1'b0;
        buf_re       = 1'b0;

        if (r_pend_valid && i_item_ready) begin
            n_pend_valid = 1'b0;
        end

        n_pend.is_status      = 1'b1;
        n_pend.payload_byte   = 8'd0;
        n_pend.byte_index     = 5'd0;
        n_pend.payload_length = 5'd0;
        n_pend.last           = 1'b1;

        unique case (r_phase)
            PH_LENGTH: begin
                if (accept) begin
                    if (i_rx_byte < srfp_pkg::MIN_LENGTH || i_rx_byte > MAX_LENGTH_B) begin
                        n_phase            = PH_HUNT;
                        n_pend_valid       = 1'b1;
                        n_pend.status_code = srfp_pkg::ST_BAD_LENGTH;
                    end else begin
                        n_phase = PH_BODY;
                        n_flen  = i_rx_byte[LEN_W-1:0];
                        n_sum   = i_rx_byte;
                        n_pos   = '0;
                        n_mis   = 1'b0;
                    end
                end
            end
            PH_BODY: begin
                if (accept) begin
                    n_sum = sum_next;
                    n_mis = mis_next;
                    if (r_pos < r_flen) begin
                        buf_we = (r_pos >= LEN_W'(srfp_pkg::HEADER_BYTES));
                        n_pos  = r_pos + LEN_W'(1);
                    end else begin
                        priority if (sum_next != 8'd0) begin
                            n_phase            = PH_HUNT;
                            n_pend_valid       = 1'b1;
                            n_pend.status_code = srfp_pkg::ST_BAD_SUM;
                        end else if (mis_next) begin
                            n_phase            = PH_HUNT;
                            n_pend_valid       = 1'b1;
                            n_pend.status_code = srfp_pkg::ST_MISMATCH;
                        end else begin
                            n_phase  = PH_READ;
                            n_plen   = PL_W'(r_flen - LEN_W'(srfp_pkg::HEADER_BYTES));
                            n_rd_idx = '0;
                        end
                    end
                end
            end
            PH_READ: begin
                if (r_rd_idx == r_plen) begin
                    n_phase               = PH_HUNT;
                    n_pend_valid          = 1'b1;
                    n_pend.status_code    = srfp_pkg::ST_OK;
                    n_pend.payload_length = 5'(r_plen);
                end else begin
                    buf_re  = 1'b1;
                    n_phase = PH_PUSH;
                end
            end
            PH_PUSH: begin
                if (i_item_ready) begin
                    n_rd_idx = r_rd_idx + PL_W'(1);
                    n_phase  = PH_READ;
                end
            end
            default: begin
                n_phase = PH_HUNT;
                if (accept) begin
                    if (i_rx_byte == srfp_pkg::START_MARK) begin
                        n_phase = PH_LENGTH;
                    end else begin
                        n_pend_valid       = 1'b1;
                        n_pend.status_code = srfp_pkg::ST_BAD_START;
                    end
                end
            end
        endcase

        if (!(n_pend_valid && !r_pend_valid)) begin
            n_pend = r_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_HUNT;
            r_flen       <= '0;
            r_pos        <= '0;
            r_sum        <= '0;
            r_mis        <= 1'b0;
            r_pend_valid <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_flen       <= n_flen;
            r_pos        <= n_pos;
            r_sum        <= n_sum;
            r_mis        <= n_mis;
            r_pend_valid <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_plen   <= n_plen;
        r_rd_idx <= n_rd_idx;
        r_pend   <= n_pend;
    end

endmodule

/* rtl/serial_reply_frame_parser.sv */
// Top level of the serial reply frame parser: configuration and output register.
//
// Input channel: one received byte per transfer on i_valid / o_stall.
// Output channel: one result item per transfer on o_valid / i_stall. Every
// stray byte, bad length, bad checksum or header mismatch gives one status
// item; a good frame gives its payload bytes in order, then an ok status.
// o_last marks the final item caused by one input byte.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (expected source, own address, expected command); other indexes are ignored.
// Flow: a status item passes through the parser's pending register and then
// the output register. Header and body bytes are taken one per cycle while
// o_stall is low. After the checksum byte of a good frame each payload byte
// is released by one buffer read and one output load, then the ok status.
// While payload is released the input channel stalls.
// Reset clears the parser to hunting for a start byte, empties the output
// register and loads the configuration defaults; the buffer is not cleared.
// When the receiver stalls, the output item holds; one further status item
// waits in a skid register, and then the input channel stalls too.
module serial_reply_frame_parser #(
    parameter int RESPONSE_BYTES = srfp_pkg::RESPONSE_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    output logic       o_is_status,
    output logic [7:0] o_payload_byte,
    output logic [4:0] o_byte_index,
    output logic [2:0] o_status_code,
    output logic [4:0] o_payload_length,
    output logic       o_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    srfp_pkg::t_cfg  r_cfg;
    srfp_pkg::t_item r_out;
    logic            r_out_valid;
    srfp_pkg::t_item item;
    logic            item_valid;
    logic            item_ready;

    srfp_parse #(
        .RESPONSE_BYTES (RESPONSE_BYTES)
    ) u_parse (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_rx_byte    (i_rx_byte),
        .o_stall      (o_stall),
        .i_cfg        (r_cfg),
        .o_item       (item),
        .o_item_valid (item_valid),
        .i_item_ready (item_ready)
    );

    assign item_ready = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_source  <= srfp_pkg::RST_EXPECTED_SOURCE;
            r_cfg.own_address      <= srfp_pkg::RST_OWN_ADDRESS;
            r_cfg.expected_command <= srfp_pkg::RST_EXPECTED_COMMAND;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                srfp_pkg::CFG_EXPECTED_SOURCE:  r_cfg.expected_source  <= i_cfg_data;
                srfp_pkg::CFG_OWN_ADDRESS:      r_cfg.own_address      <= i_cfg_data;
                srfp_pkg::CFG_EXPECTED_COMMAND: r_cfg.expected_command <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (item_ready) begin
            r_out_valid <= item_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (item_ready && item_valid) begin
            r_out <= item;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_is_status      = r_out.is_status;
    assign o_payload_byte   = r_out.payload_byte;
    assign o_byte_index     = r_out.byte_index;
    assign o_status_code    = r_out.status_code;
    assign o_payload_length = r_out.payload_length;
    assign o_last           = r_out.last;

endmodule

/* tb/sv/srfp_reply_monitor.sv */
// Channel monitor for the serial reply frame parser: predicts result items and compares them.
module srfp_reply_monitor
    import srfp_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_rx_byte,
    input  logic       i_in_stall,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic       i_is_status,
    input  logic [7:0] i_payload_byte,
    input  logic [4:0] i_byte_index,
    input  logic [2:0] i_status_code,
    input  logic [4:0] i_payload_length,
    input  logic       i_last,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    output int         o_fail_count,
    output int         o_pending
);

    localparam int MAX_LEN     = RESPONSE_BYTES_DEF - 3;
    localparam int STORE_DEPTH = RESPONSE_BYTES_DEF - 6;

    typedef enum logic [1:0] {
        SEEK_START,
        TAKE_LENGTH,
        TAKE_BODY
    } t_rx_phase;

    t_cfg       cfg;
    t_rx_phase  rx_phase;
    logic [7:0] frame_len;
    logic [7:0] frame_sum;
    int         body_pos;
    logic       hdr_bad;
    logic [7:0] payload_buf [STORE_DEPTH];
    t_item      reply_q [$];
    int         mismatches;

    function automatic t_item status_item(input t_status code, input logic [4:0] plen);
        t_item it;
        it.is_status      = 1'b1;
        it.payload_byte   = 8'd0;
        it.byte_index     = 5'd0;
        it.status_code    = code;
        it.payload_length = plen;
        it.last           = 1'b1;
        return it;
    endfunction

    task automatic decode_byte(input logic [7:0] b);
        t_item it;
        int    plen;
        case (rx_phase)
            TAKE_LENGTH: begin
                if (b < MIN_LENGTH || b > MAX_LEN) begin
                    rx_phase = SEEK_START;
                    reply_q.push_back(status_item(ST_BAD_LENGTH, 5'd0));
                end else begin
                    frame_len = b;
                    frame_sum = b;
                    body_pos  = 0;
                    hdr_bad   = 1'b0;
                    rx_phase  = TAKE_BODY;
                end
            end
            TAKE_BODY: begin
                frame_sum = frame_sum + b;
                if (body_pos == 0) begin
                    if (b != cfg.expected_source) hdr_bad = 1'b1;
                end else if (body_pos == 1) begin
                    if (b != cfg.own_address) hdr_bad = 1'b1;
                end else if (body_pos == 2) begin
                    if (b != cfg.expected_command) hdr_bad = 1'b1;
                end else if (body_pos < frame_len) begin
                    payload_buf[body_pos - HEADER_BYTES] = b;
                end
                if (body_pos < frame_len) begin
                    body_pos++;
                end else begin
                    rx_phase = SEEK_START;
                    if (frame_sum != 8'd0) begin
                        reply_q.push_back(status_item(ST_BAD_SUM, 5'd0));
                    end else if (hdr_bad) begin
                        reply_q.push_back(status_item(ST_MISMATCH, 5'd0));
                    end else begin
                        plen = frame_len - HEADER_BYTES;
                        for (int i = 0; i < plen; i++) begin
                            it.is_status      = 1'b0;
                            it.payload_byte   = payload_buf[i];
                            it.byte_index     = 5'(i);
                            it.status_code    = ST_OK;
                            it.payload_length = 5'(plen);
                            it.last           = 1'b0;
                            reply_q.push_back(it);
                        end
                        reply_q.push_back(status_item(ST_OK, 5'(plen)));
                    end
                end
            end
            default: begin
                if (b == START_MARK) begin
                    rx_phase = TAKE_LENGTH;
                end else begin
                    rx_phase = SEEK_START;
                    reply_q.push_back(status_item(ST_BAD_START, 5'd0));
                end
            end
        endcase
    endtask

    task automatic compare_item();
        t_item got;
        t_item want;
        got.is_status      = i_is_status;
        got.payload_byte   = i_payload_byte;
        got.byte_index     = i_byte_index;
        got.status_code    = t_status'(i_status_code);
        got.payload_length = i_payload_length;
        got.last           = i_last;
        if (reply_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("unexpected item: status=%0b byte=%0h idx=%0d code=%0d len=%0d last=%0b",
                         got.is_status, got.payload_byte, got.byte_index,
                         got.status_code, got.payload_length, got.last);
            end
            return;
        end
        want = reply_q.pop_front();
        if (got.is_status !== want.is_status || got.payload_byte !== want.payload_byte ||
            got.byte_index !== want.byte_index || got.status_code !== want.status_code ||
            got.payload_length !== want.payload_length || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
                $display("mismatch: exp status=%0b byte=%0h idx=%0d code=%0d len=%0d last=%0b",
                         want.is_status, want.payload_byte, want.byte_index,
                         want.status_code, want.payload_length, want.last);
                $display("          got status=%0b byte=%0h idx=%0d code=%0d len=%0d last=%0b",
                         got.is_status, got.payload_byte, got.byte_index,
                         got.status_code, got.payload_length, got.last);
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cfg.expected_source  = RST_EXPECTED_SOURCE;
            cfg.own_address      = RST_OWN_ADDRESS;
            cfg.expected_command = RST_EXPECTED_COMMAND;
            rx_phase             = SEEK_START;
            frame_len            = 8'd0;
            frame_sum            = 8'd0;
            body_pos             = 0;
            hdr_bad              = 1'b0;
            reply_q.delete();
            mismatches           = 0;
        end else begin
            if (i_out_valid && !i_out_stall) compare_item();
            if (i_valid && !i_in_stall) decode_byte(i_rx_byte);
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_EXPECTED_SOURCE:  cfg.expected_source  = i_cfg_data;
                    CFG_OWN_ADDRESS:      cfg.own_address      = i_cfg_data;
                    CFG_EXPECTED_COMMAND: cfg.expected_command = i_cfg_data;
                    default: ;
                endcase
            end
        end
        o_pending    <= reply_q.size();
        o_fail_count <= mismatches;
    end

endmodule

/* tb/sv/serial_reply_frame_parser_test.sv */
// Top-level test of the serial reply frame parser: stimulus, idling and verdict.
module serial_reply_frame_parser_test;
    import srfp_pkg::*;

    localparam logic [1:0] CFG_SPARE_IDX = 2'd3;
    localparam int         MAX_LEN       = RESPONSE_BYTES_DEF - 3;

    logic       i_clk        = 1'b0;
    logic       i_rst_n      = 1'b0;
    logic       i_valid      = 1'b0;
    logic [7:0] i_rx_byte    = 8'd0;
    logic       i_stall      = 1'b0;
    logic       i_cfg_we     = 1'b0;
    logic [1:0] i_cfg_index  = 2'd0;
    logic [7:0] i_cfg_data   = 8'd0;
    logic       o_stall;
    logic       o_valid;
    logic       o_is_status;
    logic [7:0] o_payload_byte;
    logic [4:0] o_byte_index;
    logic [2:0] o_status_code;
    logic [4:0] o_payload_length;
    logic       o_last;

    int         fail_count;
    int         pending;
    int         bytes_sent = 0;
    int         stall_hold = 0;
    bit         calm       = 1'b0;
    logic [7:0] want_src   = RST_EXPECTED_SOURCE;
    logic [7:0] want_dst   = RST_OWN_ADDRESS;
    logic [7:0] want_cmd   = RST_EXPECTED_COMMAND;

    serial_reply_frame_parser DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_rx_byte        (i_rx_byte),
        .o_stall          (o_stall),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_is_status      (o_is_status),
        .o_payload_byte   (o_payload_byte),
        .o_byte_index     (o_byte_index),
        .o_status_code    (o_status_code),
        .o_payload_length (o_payload_length),
        .o_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    srfp_reply_monitor reply_mon (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .i_rx_byte        (i_rx_byte),
        .i_in_stall       (o_stall),
        .i_out_valid      (o_valid),
        .i_out_stall      (i_stall),
        .i_is_status      (o_is_status),
        .i_payload_byte   (o_payload_byte),
        .i_byte_index     (o_byte_index),
        .i_status_code    (o_status_code),
        .i_payload_length (o_payload_length),
        .i_last           (o_last),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        return $urandom_range(1, 3);
    endfunction

    always @(negedge i_clk) begin
        if (stall_hold > 0) begin
            stall_hold <= stall_hold - 1;
        end else if (!calm && $urandom_range(0, 3) == 0) begin
            i_stall    <= 1'b1;
            stall_hold <= gap_len();
        end else begin
            i_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = (calm || $urandom_range(0, 2) != 0) ? 0 : gap_len();
        @(negedge i_clk);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid   <= 1'b1;
        i_rx_byte <= b;
        do @(posedge i_clk); while (o_stall);
        bytes_sent++;
    endtask

    task automatic send_frame(input logic [7:0] len, input logic [7:0] src,
                              input logic [7:0] dst, input logic [7:0] cmd,
                              input bit bad_sum, input logic [7:0] first_pb);
        logic [7:0] acc;
        logic [7:0] pb;
        logic [7:0] chk;
        acc = len + src + dst + cmd;
        send_byte(START_MARK);
        send_byte(len);
        send_byte(src);
        send_byte(dst);
        send_byte(cmd);
        for (int i = 0; i < int'(len) - HEADER_BYTES; i++) begin
            pb  = (i == 0) ? first_pb : 8'($urandom);
            acc = acc + pb;
            send_byte(pb);
        end
        chk = 8'd0 - acc;
        if (bad_sum) chk = chk + 8'($urandom_range(1, 255));
        send_byte(chk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            CFG_EXPECTED_SOURCE:  want_src = val;
            CFG_OWN_ADDRESS:      want_dst = val;
            CFG_EXPECTED_COMMAND: want_cmd = val;
            default: ;
        endcase
    endtask

    // hold input idle until every predicted item has left the block
    task automatic drain();
        @(negedge i_clk);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    task automatic random_frame();
        int         kind;
        int         which;
        logic [7:0] len;
        logic [7:0] flip;
        kind  = $urandom_range(0, 15);
        len   = ($urandom_range(0, 19) == 0) ? 8'(MAX_LEN) : 8'($urandom_range(3, 9));
        flip  = 8'($urandom_range(1, 255));
        which = $urandom_range(0, 2);
        if ($urandom_range(0, 5) == 0) calm = !calm;
        if (kind <= 8) begin
            send_frame(len, want_src, want_dst, want_cmd, 1'b0, 8'($urandom));
        end else if (kind <= 10) begin
            send_frame(len, want_src, want_dst, want_cmd, 1'b1, 8'($urandom));
        end else if (kind <= 12) begin
            send_frame(len, (which == 0) ? want_src ^ flip : want_src,
                       (which == 1) ? want_dst ^ flip : want_dst,
                       (which == 2) ? want_cmd ^ flip : want_cmd, 1'b0, 8'($urandom));
        end else if (kind == 13) begin
            send_byte(START_MARK);
            send_byte(($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 2))
                                                  : 8'($urandom_range(MAX_LEN + 1, 255)));
        end else begin
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom));
        end
    endtask

    task automatic run_phase(input int n);
        int start;
        start = bytes_sent;
        while (bytes_sent - start < n) random_frame();
    endtask

    initial begin
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(START_MARK);
        send_byte(8'd2);
        send_byte(START_MARK);
        send_byte(8'(MAX_LEN + 1));
        send_frame(8'd4, want_src, want_dst, want_cmd, 1'b0, START_MARK);
        send_frame(8'd3, want_src, want_dst ^ 8'h01, want_cmd, 1'b0, 8'h00);
        send_frame(8'd3, want_src, want_dst, want_cmd ^ 8'h80, 1'b1, 8'h00);
        drain();

        write_reg(CFG_EXPECTED_SOURCE, 8'h00);
        write_reg(CFG_OWN_ADDRESS, 8'hFF);
        write_reg(CFG_EXPECTED_COMMAND, 8'h00);
        write_reg(CFG_SPARE_IDX, 8'($urandom));
        send_frame(8'(MAX_LEN), want_src, want_dst, want_cmd, 1'b0, 8'hFF);
        run_phase(20);
        drain();

        write_reg(CFG_EXPECTED_SOURCE, 8'hFF);
        write_reg(CFG_OWN_ADDRESS, 8'h00);
        write_reg(CFG_EXPECTED_COMMAND, 8'hFF);
        run_phase(50);
        drain();

        write_reg(CFG_EXPECTED_SOURCE, 8'($urandom));
        write_reg(CFG_OWN_ADDRESS, 8'($urandom));
        write_reg(CFG_EXPECTED_COMMAND, 8'($urandom));
        write_reg(CFG_SPARE_IDX, 8'($urandom));
        run_phase(45);
        drain();
        repeat (20) @(posedge i_clk);

        if (fail_count == 0 && pending == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("simulation failed");
        $finish;
    end

endmodule
